// File: rtl/core/rcm_pkg.sv
// Shared types and constants for the RGBA colour matrix core.
// Used by the register block, the channel lanes, the merge stage and the top level.
package rcm_pkg;

   // Field widths.
   localparam int PIX_W              = 8;
   localparam int COEF_W             = 16;
   localparam int NUM_CHAN           = 4;
   localparam int DEF_COEF_FRAC_BITS = 12;

   // Product of a 16-bit signed coefficient and an 8-bit pixel, and the five-term sum.
   localparam int PROD_W = 24;
   localparam int ACC_W  = 28;

   // Register port geometry: 64-bit registers at byte addresses 8*i.
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int NUM_REGS   = 5;

   typedef logic [2:0] csr_index_type;

   localparam csr_index_type REG_RED_ROW    = 3'd0;
   localparam csr_index_type REG_GREEN_ROW  = 3'd1;
   localparam csr_index_type REG_BLUE_ROW   = 3'd2;
   localparam csr_index_type REG_ALPHA_ROW  = 3'd3;
   localparam csr_index_type REG_BIAS_WORDS = 3'd4;

   typedef logic [NUM_CHAN-1:0][PIX_W-1:0]  pixel_type;
   typedef logic [NUM_CHAN-1:0][COEF_W-1:0] coef_row_type;

   // Whole configuration: one coefficient row per output channel plus the biases.
   typedef struct packed {
      coef_row_type                bias;
      logic [NUM_CHAN-1:0][63:0]   rows;
   } cfg_type;

   // Input word.
   typedef struct packed {
      logic             last_in;
      logic [PIX_W-1:0] alpha_in;
      logic [PIX_W-1:0] blue_in;
      logic [PIX_W-1:0] green_in;
      logic [PIX_W-1:0] red_in;
   } req_word_type;

   // Result word.
   typedef struct packed {
      logic             last_out;
      logic [PIX_W-1:0] alpha_out;
      logic [PIX_W-1:0] blue_out;
      logic [PIX_W-1:0] green_out;
      logic [PIX_W-1:0] red_out;
   } rsp_word_type;

   // Stage enables handed to every lane.
   typedef struct packed {
      logic load_mul;
      logic load_sum;
   } lane_ctrl_type;

endpackage

// File: rtl/core/rcm_csr.sv
// Configuration registers of the colour matrix core, written and read over an APB-style port.
// Depends on rcm_pkg for the register indexes and the configuration struct.
module rcm_csr #(
   parameter int COEF_FRAC_BITS = rcm_pkg::DEF_COEF_FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [rcm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rcm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rcm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready,
   output rcm_pkg::cfg_type                 cfg
);
   import rcm_pkg::*;

   localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC_BITS;

   // Identity matrix with zero bias.
   localparam cfg_type CFG_RESET = '{
      bias: '0,
      rows: {CSR_DATA_W'(COEF_ONE) << (3 * COEF_W), CSR_DATA_W'(COEF_ONE) << (2 * COEF_W),
             CSR_DATA_W'(COEF_ONE) << COEF_W, CSR_DATA_W'(COEF_ONE)}
   };

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type index;
   logic          write_en;

   assign index      = csr_paddr[CSR_ADDR_W-1:3];
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   // Next register contents; a write to an index beyond the list changes nothing.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            REG_RED_ROW:    cfg_in.rows[0] = csr_pwdata;
            REG_GREEN_ROW:  cfg_in.rows[1] = csr_pwdata;
            REG_BLUE_ROW:   cfg_in.rows[2] = csr_pwdata;
            REG_ALPHA_ROW:  cfg_in.rows[3] = csr_pwdata;
            REG_BIAS_WORDS: cfg_in.bias    = csr_pwdata;
            default:        cfg_in         = cfg_ff;
         endcase
      end
   end

   // Reset to the identity matrix with zero bias.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read data.
   always_comb begin
      case (index)
         REG_RED_ROW:    csr_prdata = cfg_ff.rows[0];
         REG_GREEN_ROW:  csr_prdata = cfg_ff.rows[1];
         REG_BLUE_ROW:   csr_prdata = cfg_ff.rows[2];
         REG_ALPHA_ROW:  csr_prdata = cfg_ff.rows[3];
         REG_BIAS_WORDS: csr_prdata = cfg_ff.bias;
         default:        csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/core/rcm_lane.sv
// One output channel of the colour matrix: four products and a bias term, then sum, round, clamp.
// Depends on rcm_pkg for widths and the lane control struct.
module rcm_lane #(
   parameter int COEF_FRAC_BITS = rcm_pkg::DEF_COEF_FRAC_BITS
) (
   input  logic                        clock,
   input  rcm_pkg::lane_ctrl_type      ctrl,
   input  rcm_pkg::pixel_type          pix,
   input  rcm_pkg::coef_row_type       row,
   input  logic [rcm_pkg::COEF_W-1:0]  bias,
   output logic [rcm_pkg::PIX_W-1:0]   chan
);
   import rcm_pkg::*;

   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

   logic signed [PROD_W-1:0] coef_ext [NUM_CHAN];
   logic signed [PROD_W-1:0] pix_ext  [NUM_CHAN];
   logic signed [PROD_W-1:0] prod_in  [NUM_CHAN];
   logic signed [PROD_W-1:0] prod_ff  [NUM_CHAN];
   logic signed [PROD_W-1:0] bias_ext;
   logic signed [PROD_W-1:0] bias_term_in;
   logic signed [PROD_W-1:0] bias_term_ff;
   logic signed [ACC_W-1:0]  acc;
   logic [PIX_W-1:0]         chan_in;
   logic [PIX_W-1:0]         chan_ff;

   // Stage one: coefficient times pixel for each input channel, and bias scaled by 255.
   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         coef_ext[i] = PROD_W'($signed(row[i]));
         pix_ext[i]  = PROD_W'({1'b0, pix[i]});
         prod_in[i]  = coef_ext[i] * pix_ext[i];
      end
      bias_ext     = PROD_W'($signed(bias));
      bias_term_in = (bias_ext <<< PIX_W) - bias_ext;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_mul) begin
         prod_ff      <= prod_in;
         bias_term_ff <= bias_term_in;
      end
   end

   // Stage two: sum with the rounding half, then clamp to the pixel range.
   always_comb begin
      acc = ROUND_HALF + ACC_W'(bias_term_ff);
      for (int i = 0; i < NUM_CHAN; i++) begin
         acc = acc + ACC_W'(prod_ff[i]);
      end
      if (acc[ACC_W-1]) begin
         chan_in = '0;
      end else if (|acc[ACC_W-2:COEF_FRAC_BITS+PIX_W]) begin
         chan_in = '1;
      end else begin
         chan_in = acc[COEF_FRAC_BITS+PIX_W-1:COEF_FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_sum) begin
         chan_ff <= chan_in;
      end
   end

   assign chan = chan_ff;

endmodule

// File: rtl/core/rcm_merge.sv
// Merge stage: gathers the four lane results and the last flag into the output word register.
// Depends on rcm_pkg for the pixel and result word types.
module rcm_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  sum_valid,
   input  rcm_pkg::pixel_type    chans,
   input  logic                  last,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output rcm_pkg::rsp_word_type rsp_word,
   output logic                  load_out
);
   import rcm_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;
   rsp_word_type word_in;

   // The output register takes a new word when empty or when its word leaves.
   assign load_out = !valid_ff || !rsp_stall;
   assign valid_in = load_out ? sum_valid : valid_ff;

   always_comb begin
      word_in.red_out   = chans[0];
      word_in.green_out = chans[1];
      word_in.blue_out  = chans[2];
      word_in.alpha_out = chans[3];
      word_in.last_out  = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out && sum_valid) begin
         word_ff <= word_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

// File: rtl/core/rgba_color_matrix_core.sv
// Pipeline: an accepted word passes the product register, the sum and clamp register and the
// output register before it shows on rsp_valid, and waits longer while the output is stalled.
// Throughput: one word per clock while rsp_stall is low, set by the four channel lanes side by side.
// Reset (synchronous, active high): pipeline empty, identity matrix, zero bias.
module rgba_color_matrix_core #(
   parameter int COEF_FRAC_BITS = rcm_pkg::DEF_COEF_FRAC_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  rcm_pkg::req_word_type           req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output rcm_pkg::rsp_word_type           rsp_word,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rcm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rcm_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rcm_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import rcm_pkg::*;

   cfg_type       cfg;
   pixel_type     pix;
   pixel_type     chans;
   lane_ctrl_type lane_ctrl;
   logic          v1_ff;
   logic          v1_in;
   logic          v2_ff;
   logic          v2_in;
   logic          last1_ff;
   logic          last2_ff;
   logic          adv1;
   logic          adv2;
   logic          load_out;

   // Register block.
   rcm_csr #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Stall chain: a stage moves on when it is empty or the stage after it moves on.
   assign adv2      = !v2_ff || load_out;
   assign adv1      = !v1_ff || adv2;
   assign req_stall = !adv1;
   assign v1_in     = adv1 ? req_valid : v1_ff;
   assign v2_in     = adv2 ? v1_ff : v2_ff;

   assign lane_ctrl.load_mul = adv1;
   assign lane_ctrl.load_sum = adv2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   // The last flag travels alongside the lane stages.
   always_ff @(posedge clock) begin
      if (adv1) begin
         last1_ff <= req_word.last_in;
      end
      if (adv2) begin
         last2_ff <= last1_ff;
      end
   end

   assign pix = {req_word.alpha_in, req_word.blue_in, req_word.green_in, req_word.red_in};

   // One lane per output channel.
   for (genvar k = 0; k < NUM_CHAN; k++) begin : g_lane
      rcm_lane #(
         .COEF_FRAC_BITS(COEF_FRAC_BITS)
      ) u_lane (
         .clock (clock),
         .ctrl  (lane_ctrl),
         .pix   (pix),
         .row   (cfg.rows[k]),
         .bias  (cfg.bias[k]),
         .chan  (chans[k])
      );
   end

   // Output word register.
   rcm_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .sum_valid (v2_ff),
      .chans     (chans),
      .last      (last2_ff),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .load_out  (load_out)
   );

`ifndef SYNTHESIS
   // The input is only held off when the first stage holds a word.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> v1_ff)
      else $error("input stalled with an empty first stage");

   // An accepted word always lands in the first stage.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted word lost at the first stage");

   // A finished sum moving into the output register shows up as a valid word.
   assert property (@(posedge clock) disable iff (reset)
      (v2_ff && load_out) |=> rsp_valid)
      else $error("finished word did not reach the output");

   // Reset empties the whole pipeline.
   assert property (@(posedge clock) reset |=> (!rsp_valid && !v1_ff && !v2_ff))
      else $error("pipeline not empty after reset");
`endif

endmodule

// File: sim/tb_rgba_color_matrix_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for rgba_color_matrix_core: pixel words in, mixed pixel words out,
// with a coefficient and bias set written over the register port between phases.
// Depends on rcm_pkg and the core RTL; nothing else is read.
module tb_rgba_color_matrix_core;
   import rcm_pkg::*;

   localparam int          FRAC_BITS     = DEF_COEF_FRAC_BITS;
   localparam logic [15:0] COEF_ONE      = 16'(1 << FRAC_BITS);
   localparam logic [15:0] COEF_NEG_ONE  = 16'(-(1 << FRAC_BITS));
   localparam logic [15:0] COEF_HALF     = 16'(1 << (FRAC_BITS - 1));
   localparam logic [15:0] COEF_NEG_HALF = 16'(-(1 << (FRAC_BITS - 1)));
   localparam logic [15:0] COEF_MAX      = 16'h7FFF;
   localparam logic [15:0] COEF_MIN      = 16'h8000;
   localparam int          MAX_WAIT      = 14;
   localparam int          PIPE_DEPTH    = 3;
   localparam int          DRAIN_LIMIT   = 20000;
   localparam int          RANDOM_PHASES = 12;
   localparam int          PHASE_PIXELS  = 78;
   localparam int          INDEX_SPAN    = 1 << $bits(csr_index_type);

   typedef enum int {PACE_NONE, PACE_LIGHT, PACE_HEAVY} pace_type;
   typedef enum int {COEF_FULL, COEF_EXTREME, COEF_GENTLE} coef_style_type;
   typedef logic [CSR_DATA_W-1:0] cfg_words_type [NUM_REGS];
   typedef struct {
      req_word_type word;
      int unsigned  gap;
   } queued_pixel_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_word_type          req_word    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_word_type          rsp_word;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Copy of the register file as the block should hold it.
   cfg_words_type         cfg_shadow;
   queued_pixel_type      pixel_queue[$];
   rsp_word_type          expected_pixels[$];
   int unsigned           pixels_queued   = 0;
   int unsigned           pixels_accepted = 0;
   int unsigned           fail_count      = 0;
   logic                  req_fire        = 1'b0;
   logic                  rsp_fire        = 1'b0;
   logic                  presenting      = 1'b0;
   int unsigned           gap_count       = 0;
   int unsigned           stall_left      = 0;
   pace_type              src_pace        = PACE_NONE;
   pace_type              sink_pace       = PACE_NONE;

   rgba_color_matrix_core #(
      .COEF_FRAC_BITS (FRAC_BITS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // Wait length for one word under the given pacing.
   function automatic int unsigned draw_wait(pace_type pace);
      case (pace)
         PACE_HEAVY: return $urandom_range(0, MAX_WAIT);
         PACE_LIGHT: return ($urandom_range(0, 5) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
         default:    return 0;
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pack_coefs(logic [15:0] r, logic [15:0] g,
                                                         logic [15:0] b, logic [15:0] a);
      return {a, b, g, r};
   endfunction

   // Expected output word for one pixel under the current shadow registers.
   function automatic rsp_word_type mix_pixel(req_word_type w);
      rsp_word_type     mixed;
      logic [PIX_W-1:0] chan_in [NUM_CHAN];
      logic [PIX_W-1:0] chan_out [NUM_CHAN];
      longint           acc;
      int               k;
      int               i;
      chan_in[0] = w.red_in;
      chan_in[1] = w.green_in;
      chan_in[2] = w.blue_in;
      chan_in[3] = w.alpha_in;
      for (k = 0; k < NUM_CHAN; k++) begin
         acc = longint'(shortint'(cfg_shadow[REG_BIAS_WORDS][COEF_W*k +: COEF_W])) * 255;
         for (i = 0; i < NUM_CHAN; i++) begin
            acc += longint'(shortint'(cfg_shadow[k][COEF_W*i +: COEF_W])) * longint'(chan_in[i]);
         end
         // Round to nearest, ties upwards, then clamp to the pixel range.
         acc += longint'(1) << (FRAC_BITS - 1);
         if (acc < 0) begin
            chan_out[k] = '0;
         end else if ((acc >>> FRAC_BITS) > 255) begin
            chan_out[k] = '1;
         end else begin
            chan_out[k] = PIX_W'(acc >>> FRAC_BITS);
         end
      end
      mixed.red_out   = chan_out[0];
      mixed.green_out = chan_out[1];
      mixed.blue_out  = chan_out[2];
      mixed.alpha_out = chan_out[3];
      mixed.last_out  = w.last_in;
      return mixed;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s expected %0d got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Sample both handshakes and the register port; predict and compare.
   always @(posedge clock) begin : monitor
      rsp_word_type want;
      int           k;
      req_fire = (reset === 1'b0) && (req_valid === 1'b1) && (req_stall === 1'b0);
      rsp_fire = (reset === 1'b0) && (rsp_valid === 1'b1) && (rsp_stall === 1'b0);
      if (reset) begin
         for (k = 0; k < NUM_REGS; k++) begin
            cfg_shadow[k] = '0;
            if (k < NUM_CHAN) begin
               cfg_shadow[k][COEF_W*k +: COEF_W] = COEF_ONE;
            end
         end
      end else if (csr_psel && csr_penable && csr_pwrite && (csr_pready === 1'b1)
                   && (csr_paddr[CSR_ADDR_W-1:3] < NUM_REGS)) begin
         cfg_shadow[csr_paddr[CSR_ADDR_W-1:3]] = csr_pwdata;
      end
      if (req_fire) begin
         expected_pixels.push_back(mix_pixel(req_word));
         pixels_accepted++;
      end
      if (rsp_fire) begin
         if (expected_pixels.size() == 0) begin
            $error("result word %h arrived with no pixel outstanding", rsp_word);
            fail_count++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("red_out", want.red_out, rsp_word.red_out);
            check_field("green_out", want.green_out, rsp_word.green_out);
            check_field("blue_out", want.blue_out, rsp_word.blue_out);
            check_field("alpha_out", want.alpha_out, rsp_word.alpha_out);
            check_field("last_out", want.last_out, rsp_word.last_out);
         end
      end
   end

   // Sender: presents queued pixel words after each word's own gap.
   always @(negedge clock) begin : driver
      if (reset) begin
         presenting = 1'b0;
         gap_count  = 0;
         req_valid <= 1'b0;
      end else begin
         if (req_fire) begin
            presenting = 1'b0;
         end
         if (!presenting && pixel_queue.size() > 0) begin
            if (gap_count < pixel_queue[0].gap) begin
               gap_count++;
            end else begin
               req_word <= pixel_queue[0].word;
               void'(pixel_queue.pop_front());
               presenting = 1'b1;
               gap_count  = 0;
            end
         end
         req_valid <= presenting;
      end
   end

   // Receiver: holds off for a drawn number of cycles after each result word.
   always @(negedge clock) begin : receiver
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_fire) begin
            stall_left = draw_wait(sink_pace);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // One register transfer: setup cycle, then access until pready.
   task automatic csr_transfer(input logic is_write, input csr_index_type idx,
                               input logic [CSR_DATA_W-1:0] wdata,
                               output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= is_write;
      csr_paddr   <= CSR_ADDR_W'(idx * 8);
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Read every mapped register back and compare with the shadow copy.
   task automatic verify_cfg();
      logic [CSR_DATA_W-1:0] got;
      int                    k;
      for (k = 0; k < NUM_REGS; k++) begin
         csr_transfer(1'b0, csr_index_type'(k), '0, got);
         if (got !== cfg_shadow[k]) begin
            $error("register %0d expected %h got %h", k, cfg_shadow[k], got);
            fail_count++;
         end
      end
   endtask

   task automatic load_cfg(input cfg_words_type words);
      logic [CSR_DATA_W-1:0] unused;
      int                    k;
      for (k = 0; k < NUM_REGS; k++) begin
         csr_transfer(1'b1, csr_index_type'(k), words[k], unused);
      end
      verify_cfg();
   endtask

   // Writes to the indexes past the register list must leave the registers untouched.
   task automatic poke_unmapped();
      logic [CSR_DATA_W-1:0] unused;
      int                    idx;
      for (idx = NUM_REGS; idx < INDEX_SPAN; idx++) begin
         csr_transfer(1'b1, csr_index_type'(idx), {$urandom, $urandom}, unused);
      end
      verify_cfg();
   endtask

   function automatic void push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                      logic [7:0] a, logic last);
      queued_pixel_type item;
      item.word.red_in   = r;
      item.word.green_in = g;
      item.word.blue_in  = b;
      item.word.alpha_in = a;
      item.word.last_in  = last;
      item.gap           = draw_wait(src_pace);
      pixel_queue.push_back(item);
      pixels_queued++;
   endfunction

   // Hold the sender back until every outstanding result word has been checked.
   task automatic drain_pixels();
      int unsigned waited;
      waited = 0;
      while (!(pixel_queue.size() == 0 && pixels_accepted == pixels_queued
               && expected_pixels.size() == 0) && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (waited >= DRAIN_LIMIT) begin
         $error("pipeline did not drain, %0d result words outstanding", expected_pixels.size());
         fail_count++;
         expected_pixels.delete();
      end
      repeat (PIPE_DEPTH + 1) @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_coef_word(coef_style_type style, int span);
      logic [CSR_DATA_W-1:0] w;
      int                    i;
      w = {$urandom, $urandom};
      if (style != COEF_FULL) begin
         for (i = 0; i < NUM_CHAN; i++) begin
            if (style == COEF_GENTLE) begin
               w[COEF_W*i +: COEF_W] = 16'(int'($urandom_range(0, 2 * span)) - span);
            end else begin
               case ($urandom_range(0, 4))
                  0:       w[COEF_W*i +: COEF_W] = COEF_MAX;
                  1:       w[COEF_W*i +: COEF_W] = COEF_MIN;
                  2:       w[COEF_W*i +: COEF_W] = '0;
                  3:       w[COEF_W*i +: COEF_W] = '1;
                  default: w[COEF_W*i +: COEF_W] = COEF_ONE;
               endcase
            end
         end
      end
      return w;
   endfunction

   function automatic logic [7:0] random_level();
      if ($urandom_range(0, 7) == 0) begin
         return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // One random phase: new settings, half the pixels, a full pause, the other half.
   task automatic run_random_phase(input int p);
      cfg_words_type words;
      int            k;
      int            n;
      src_pace  = pace_type'((p / 3) % 3);
      sink_pace = pace_type'((p / 2) % 3);
      for (k = 0; k < NUM_CHAN; k++) begin
         words[k] = random_coef_word(coef_style_type'(p % 3), int'(COEF_ONE));
      end
      words[REG_BIAS_WORDS] = random_coef_word(coef_style_type'(p % 3), int'(COEF_ONE) / 4);
      load_cfg(words);
      if ($urandom_range(0, 2) == 0) begin
         poke_unmapped();
      end
      for (n = 0; n < PHASE_PIXELS; n++) begin
         if (n == PHASE_PIXELS / 2) begin
            drain_pixels();
         end
         push_pixel(random_level(), random_level(), random_level(), random_level(),
                    $urandom_range(0, 7) == 0);
      end
      drain_pixels();
   endtask

   initial begin : stimulus
      cfg_words_type words;
      int            p;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Reset settings: identity matrix, zero bias.
      verify_cfg();
      push_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      push_pixel(8'h01, 8'h02, 8'h03, 8'h04, 1'b0);
      push_pixel(8'h80, 8'h7F, 8'h40, 8'hC8, 1'b1);
      drain_pixels();

      // Largest coefficients and bias: every channel saturates high.
      words = '{pack_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX),
                pack_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX),
                pack_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX),
                pack_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX),
                pack_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX)};
      load_cfg(words);
      push_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
      push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      drain_pixels();

      // Most negative coefficients and bias: every channel clamps to zero.
      words = '{pack_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN),
                pack_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN),
                pack_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN),
                pack_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN),
                pack_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN)};
      load_cfg(words);
      push_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      push_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
      drain_pixels();

      // Half-way ties on red and green, inversion of blue through a full bias.
      words = '{pack_coefs(COEF_HALF, '0, '0, '0),
                pack_coefs('0, COEF_NEG_HALF, '0, '0),
                pack_coefs('0, '0, COEF_NEG_ONE, '0),
                pack_coefs('0, '0, '0, COEF_ONE),
                pack_coefs('0, '0, COEF_ONE, '0)};
      load_cfg(words);
      push_pixel(8'h01, 8'h01, 8'h00, 8'h00, 1'b0);
      push_pixel(8'h03, 8'h03, 8'hFF, 8'h0A, 1'b1);
      push_pixel(8'hFF, 8'hFF, 8'h80, 8'hFF, 1'b0);
      push_pixel(8'h07, 8'hC8, 8'h01, 8'h00, 1'b1);
      drain_pixels();

      // Channel swizzle, then writes past the register list must change nothing.
      words = '{pack_coefs('0, '0, '0, COEF_ONE),
                pack_coefs('0, '0, COEF_ONE, '0),
                pack_coefs('0, COEF_ONE, '0, '0),
                pack_coefs(COEF_ONE, '0, '0, '0),
                pack_coefs(COEF_NEG_HALF, '0, COEF_HALF, '0)};
      load_cfg(words);
      poke_unmapped();
      push_pixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b0);
      push_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1);
      push_pixel(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b0);
      drain_pixels();

      for (p = 0; p < RANDOM_PHASES; p++) begin
         run_random_phase(p);
      end

      drain_pixels();
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Safety net well beyond the slowest legal run.
   initial begin : watchdog
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
